### rtl/rfem_pkg.sv
`default_nettype none
package rfem_pkg;

	localparam int FRAME_BYTES = 10;
	localparam int TIME_W      = 32;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int BCNT_W      = 7;
	localparam int CFG_IDX_W   = 3;

	localparam logic [BCNT_W-1:0] FRAME_BITS = BCNT_W'(FRAME_BYTES * 8);
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(FRAME_BYTES - 1);

	// preamble and sync windows, exclusive bounds in microseconds
	localparam logic [TIME_W-1:0] PRE_LO  = TIME_W'(2400);
	localparam logic [TIME_W-1:0] PRE_HI  = TIME_W'(2700);
	localparam logic [TIME_W-1:0] SYNC_LO = TIME_W'(4700);
	localparam logic [TIME_W-1:0] SYNC_HI = TIME_W'(5000);

	localparam logic [7:0] CHK_SEED  = 8'd163;
	localparam logic [7:0] REPORT_B0 = 8'd164;
	localparam logic [3:0] CHK_HI    = 4'hf;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_OFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLITCH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd4;

	typedef enum logic [2:0] {
		RX_IDLE = 3'd0,
		RX_WAIT = 3'd1,
		RX_DATA = 3'd2,
		RX_DONE = 3'd3,
		RX_PERR = 3'd4,
		RX_DERR = 3'd5
	} rx_state_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] edge_time_us;
	} in_item_t;

	typedef struct packed {
		logic [2:0] rx_state;
		logic [6:0] bit_count;
		logic       byte_valid;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic       checksum_ok;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic decide;
		logic put_stat;
		logic rd;
		logic acc;
		logic chk;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fin;
		logic slot_free;
		logic last_idx;
	} sts_t;

endpackage
`default_nettype wire

### rtl/rf_edge_manchester_frame_receiver_unit.sv
// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------
// input     | in_valid / in_stall      | in_item  (edge or clear request)
// result    | out_valid / out_stall    | out_item (status or frame byte)
// config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// a request that gives a status result passes through accept, interval and
// gap compute, receiver update, result write
// the edge that ends a frame goes on to walk the byte memory, which has one
// registered read port, twice: once for the checksum and once to emit the bytes
// out_stall holds the result register and the controller waits on it
// reset brings the controller, receiver, config and result-valid registers to their
// reset values at once; the byte memory is always fully written before it is read
`default_nettype none
module rf_edge_manchester_frame_receiver_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rfem_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rfem_pkg::out_item_t                 out_item,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rfem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import rfem_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rfem_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	rfem_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
`default_nettype wire

### rtl/rfem_ram.sv
`default_nettype none
module rfem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/rfem_dp.sv
`default_nettype none
module rfem_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rfem_pkg::cmd_t              cmd,
	output rfem_pkg::sts_t                   sts,
	input  wire rfem_pkg::in_item_t          in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output rfem_pkg::out_item_t              out_item,
	input  wire logic                        cfg_valid,
	input  wire logic [rfem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                 cfg_data
);
	import rfem_pkg::*;

	logic [15:0]       cfg_hmin_q, cfg_hmax_q, cfg_soff_q, cfg_glim_q;
	logic [31:0]       cfg_gap_q;

	logic              typ_q;
	logic [TIME_W-1:0] t_q, ref_q, act_q, dur_q;
	logic              gap_hit_q;

	rx_state_t         rxst_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic              prev_q, hw_q;
	logic [6:0]        acc_q;

	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        prv_raw_q, chk_q;
	logic [3:0]        c_q;
	logic              ok_q;

	logic              out_valid_q;
	out_item_t         out_q;

	// next-state of the receiver for the decide step
	rx_state_t         st_d;
	logic [BCNT_W-1:0] cnt_d;
	logic              prev_d, hw_d, store, sbit, fin;
	logic [TIME_W-1:0] ref_d, act_d, tnew;
	logic              pre_win, sync_win, full_win, half_win, above_glitch;

	logic [7:0]        raw, dec, cb;
	logic              ram_we;

	assign above_glitch = dur_q > TIME_W'(cfg_glim_q);
	assign pre_win  = (dur_q > PRE_LO) && (dur_q < PRE_HI);
	assign sync_win = (dur_q > SYNC_LO) && (dur_q < SYNC_HI);
	assign full_win = (dur_q > TIME_W'({cfg_hmin_q, 1'b0}))
		&& (dur_q < TIME_W'({cfg_hmax_q, 1'b0}));
	assign half_win = (dur_q > TIME_W'(cfg_hmin_q)) && (dur_q < TIME_W'(cfg_hmax_q));

	always_comb begin
		st_d   = rxst_q;
		cnt_d  = bcnt_q;
		prev_d = prev_q;
		hw_d   = hw_q;
		ref_d  = ref_q;
		act_d  = act_q;
		store  = 1'b0;
		sbit   = prev_q;
		tnew   = t_q;
		fin    = 1'b0;
		if (typ_q) begin
			st_d   = RX_IDLE;
			cnt_d  = '0;
			prev_d = 1'b0;
			hw_d   = 1'b0;
		end else if (gap_hit_q) begin
			st_d   = RX_WAIT;
			cnt_d  = '0;
			prev_d = 1'b0;
			hw_d   = 1'b0;
			ref_d  = t_q;
			act_d  = t_q;
		end else if (!(rxst_q inside {RX_PERR, RX_DERR})) begin
			act_d = t_q;
			if (above_glitch) begin
				case (rxst_q)
					RX_WAIT: begin
						if (pre_win) begin
							st_d = RX_WAIT;
						end else if (sync_win) begin
							st_d   = RX_DATA;
							prev_d = 1'b1;
							tnew   = t_q + TIME_W'(cfg_soff_q);
						end else begin
							st_d = RX_PERR;
						end
					end
					RX_DATA: begin
						// full-bit window wins where the two overlap
						if (full_win) begin
							prev_d = ~prev_q;
							store  = 1'b1;
							sbit   = ~prev_q;
						end else if (half_win) begin
							if (hw_q) begin
								hw_d = 1'b0;
							end else begin
								hw_d  = 1'b1;
								store = 1'b1;
								sbit  = prev_q;
							end
						end else begin
							st_d = RX_DERR;
						end
					end
					default: begin
						st_d = rxst_q;
					end
				endcase
			end
			ref_d = tnew;
			if (store) begin
				cnt_d = bcnt_q + BCNT_W'(1);
			end
			if (st_d == RX_DATA && cnt_d == FRAME_BITS) begin
				st_d = RX_DONE;
				fin  = 1'b1;
			end
		end
	end

	// a byte is written once its eighth bit arrives
	assign ram_we = cmd.decide && store && (bcnt_q[2:0] == 3'd7);

	rfem_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_bytes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bcnt_q[BCNT_W-1:3]),
		.wdata({acc_q, sbit}),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(raw)
	);

	assign dec = (idx_q == '0) ? raw : (raw ^ prv_raw_q);
	assign cb  = (idx_q == '0) ? CHK_SEED : (idx_q == IDX_W'(1)) ? 8'd0 : dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hmin_q <= 16'd500;
			cfg_hmax_q <= 16'd800;
			cfg_soff_q <= 16'd650;
			cfg_glim_q <= 16'd100;
			cfg_gap_q  <= 32'd100000;
			rxst_q     <= RX_IDLE;
			bcnt_q     <= '0;
			prev_q     <= 1'b0;
			hw_q       <= 1'b0;
			ref_q      <= '0;
			act_q      <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_HALF_MIN: cfg_hmin_q <= cfg_data[15:0];
					CFG_HALF_MAX: cfg_hmax_q <= cfg_data[15:0];
					CFG_SYNC_OFF: cfg_soff_q <= cfg_data[15:0];
					CFG_GLITCH:   cfg_glim_q <= cfg_data[15:0];
					CFG_GAP:      cfg_gap_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.decide) begin
				rxst_q <= st_d;
				bcnt_q <= cnt_d;
				prev_q <= prev_d;
				hw_q   <= hw_d;
				ref_q  <= ref_d;
				act_q  <= act_d;
			end
			if (cmd.chk && chk_q[7:4] == CHK_HI && chk_q[3:0] == c_q) begin
				bcnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			typ_q <= in_item.req_type;
			t_q   <= TIME_W'(in_item.edge_time_us);
		end
		if (cmd.calc) begin
			gap_hit_q <= (t_q - act_q) > TIME_W'(cfg_gap_q);
			dur_q     <= t_q - ref_q;
		end
		if (cmd.decide) begin
			idx_q <= '0;
			c_q   <= '0;
			if (store) begin
				acc_q <= {acc_q[5:0], sbit};
			end
		end
		if (cmd.acc) begin
			c_q       <= c_q ^ cb[7:4] ^ cb[3:0];
			prv_raw_q <= raw;
			idx_q     <= idx_q + IDX_W'(1);
			if (idx_q == IDX_W'(1)) begin
				chk_q <= dec;
			end
		end
		if (cmd.chk) begin
			ok_q  <= (chk_q[7:4] == CHK_HI) && (chk_q[3:0] == c_q);
			idx_q <= '0;
		end
		if (cmd.emit) begin
			prv_raw_q <= raw;
			idx_q     <= idx_q + IDX_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put_stat || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_stat) begin
			out_q.rx_state    <= rxst_q;
			out_q.bit_count   <= bcnt_q;
			out_q.byte_valid  <= 1'b0;
			out_q.byte_index  <= '0;
			out_q.byte_value  <= '0;
			out_q.checksum_ok <= 1'b0;
			out_q.last        <= 1'b1;
		end else if (cmd.emit) begin
			out_q.rx_state    <= rxst_q;
			out_q.bit_count   <= bcnt_q;
			out_q.byte_valid  <= 1'b1;
			out_q.byte_index  <= 4'(idx_q);
			out_q.byte_value  <= (idx_q == '0) ? REPORT_B0 : dec;
			out_q.checksum_ok <= ok_q;
			out_q.last        <= (idx_q == LAST_IDX);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign sts.fin       = fin;
	assign sts.slot_free = !out_valid_q || !out_stall;
	assign sts.last_idx  = (idx_q == LAST_IDX);

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide && fin |=> rxst_q == RX_DONE && bcnt_q == FRAME_BITS)
		else $error("frame end did not land in finished state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= FRAME_BITS)
		else $error("bit counter beyond frame length");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.byte_valid && out_q.last |-> out_q.byte_index == 4'(LAST_IDX))
		else $error("last byte result at wrong index");

endmodule
`default_nettype wire

### rtl/rfem_ctrl.sv
`default_nettype none
module rfem_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire rfem_pkg::sts_t sts,
	output rfem_pkg::cmd_t      cmd
);
	import rfem_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_DECIDE,
		S_PUT,
		S_RD1,
		S_ACC1,
		S_CHK,
		S_RD2,
		S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= sts.fin ? S_RD1 : S_PUT;
				end
				S_PUT: begin
					if (sts.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RD1: begin
					state_q <= S_ACC1;
				end
				S_ACC1: begin
					state_q <= sts.last_idx ? S_CHK : S_RD1;
				end
				S_CHK: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.slot_free) begin
						state_q <= sts.last_idx ? S_IDLE : S_RD2;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.calc     = (state_q == S_CALC);
	assign cmd.decide   = (state_q == S_DECIDE);
	assign cmd.put_stat = (state_q == S_PUT) && sts.slot_free;
	assign cmd.rd       = (state_q == S_RD1) || (state_q == S_RD2);
	assign cmd.acc      = (state_q == S_ACC1);
	assign cmd.chk      = (state_q == S_CHK);
	assign cmd.emit     = (state_q == S_EMIT) && sts.slot_free;

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_CALC)
		else $error("accepted request not processed");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !sts.slot_free |=> state_q == S_EMIT)
		else $error("byte result dropped while output full");

	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_stat || cmd.emit |-> sts.slot_free)
		else $error("result written into full output register");

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
module tb_top;
	import rfem_pkg::*;

	localparam logic REQ_EDGE    = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   SETTLE      = 64;
	localparam int   NBITS       = FRAME_BYTES * 8;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	rf_edge_manchester_frame_receiver_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// receiver copy: registers and decoder state
	logic [15:0] half_min_us  = 16'd500;
	logic [15:0] half_max_us  = 16'd800;
	logic [15:0] sync_off_us  = 16'd650;
	logic [15:0] glitch_us    = 16'd100;
	logic [31:0] gap_us       = 32'd100000;
	rx_state_t   rx_st        = RX_IDLE;
	logic [6:0]  bits_rcvd    = '0;
	logic        prev_bit     = 1'b0;
	logic        half_pending = 1'b0;
	logic        frame_bits [NBITS];
	logic [31:0] ref_time     = '0;
	logic [31:0] last_activity = '0;

	out_item_t   expected_results [$];

	int          err_count      = 0;
	int          items_sent     = 0;
	int          results_seen   = 0;
	int          frames_ok      = 0;
	int          frames_bad     = 0;
	int          settings_count = 0;
	int          cycle_count    = 0;
	int          send_idle_pct  = 14;
	int          stall_pct      = 78;
	logic        hold_results   = 1'b0;
	logic [31:0] tx_time        = '0;
	bit          next_good_sum  = 1'b1;

	task automatic flag_error(string msg);
		err_count++;
		if (err_count <= 40)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic push_result(logic valid, logic [3:0] idx, logic [7:0] val, logic ok,
			logic fin);
		out_item_t r;
		r.rx_state    = rx_st;
		r.bit_count   = bits_rcvd;
		r.byte_valid  = valid;
		r.byte_index  = idx;
		r.byte_value  = val;
		r.checksum_ok = ok;
		r.last        = fin;
		expected_results.push_back(r);
	endtask

	task automatic save_bit(logic b);
		if (bits_rcvd < FRAME_BITS) begin
			frame_bits[bits_rcvd] = b;
			bits_rcvd++;
		end
	endtask

	task automatic decode_request(in_item_t req);
		logic [31:0] t;
		logic [31:0] dur;
		logic [16:0] lo2;
		logic [16:0] hi2;
		logic        finishes;
		logic [7:0]  raw_cur;
		logic [7:0]  raw_prev;
		logic [7:0]  dec_b [FRAME_BYTES];
		logic [3:0]  sum;
		logic        sum_ok;
		t = req.edge_time_us;
		finishes = 1'b0;
		raw_prev = '0;
		if (req.req_type == REQ_CLEAR) begin
			rx_st = RX_IDLE;
			bits_rcvd = '0;
			prev_bit = 1'b0;
			half_pending = 1'b0;
			push_result(1'b0, '0, '0, 1'b0, 1'b1);
			return;
		end
		if (t - last_activity > gap_us) begin
			rx_st = RX_WAIT;
			bits_rcvd = '0;
			prev_bit = 1'b0;
			half_pending = 1'b0;
			ref_time = t;
			last_activity = t;
			push_result(1'b0, '0, '0, 1'b0, 1'b1);
			return;
		end
		if (rx_st == RX_PERR || rx_st == RX_DERR) begin
			push_result(1'b0, '0, '0, 1'b0, 1'b1);
			return;
		end
		dur = t - ref_time;
		last_activity = t;
		if (dur > glitch_us) begin
			if (rx_st == RX_WAIT) begin
				if (dur > PRE_LO && dur < PRE_HI) begin
					// still in the preamble
				end else if (dur > SYNC_LO && dur < SYNC_HI) begin
					rx_st = RX_DATA;
					prev_bit = 1'b1;
					t = t + sync_off_us;
				end else begin
					rx_st = RX_PERR;
				end
			end else if (rx_st == RX_DATA) begin
				lo2 = {half_min_us, 1'b0};
				hi2 = {half_max_us, 1'b0};
				// full-bit window wins where the two overlap
				if (dur > lo2 && dur < hi2) begin
					prev_bit = ~prev_bit;
					save_bit(prev_bit);
				end else if (dur > half_min_us && dur < half_max_us) begin
					if (half_pending) begin
						half_pending = 1'b0;
					end else begin
						half_pending = 1'b1;
						save_bit(prev_bit);
					end
				end else begin
					rx_st = RX_DERR;
				end
				if (rx_st == RX_DATA && bits_rcvd == FRAME_BITS) begin
					rx_st = RX_DONE;
					finishes = 1'b1;
				end
			end
		end
		ref_time = t;
		if (!finishes) begin
			push_result(1'b0, '0, '0, 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < FRAME_BYTES; i++) begin
			raw_cur = '0;
			for (int j = 0; j < 8; j++)
				raw_cur = {raw_cur[6:0], frame_bits[i*8+j]};
			dec_b[i] = (i == 0) ? raw_cur : raw_cur ^ raw_prev;
			raw_prev = raw_cur;
		end
		// byte0 counts as the seed value, byte1 as zero
		sum = CHK_SEED[3:0] ^ CHK_SEED[7:4];
		for (int i = 2; i < FRAME_BYTES; i++)
			sum ^= dec_b[i][3:0] ^ dec_b[i][7:4];
		sum_ok = (dec_b[1] == {CHK_HI, sum});
		dec_b[0] = REPORT_B0;
		if (sum_ok) begin
			bits_rcvd = '0;
			frames_ok++;
		end else begin
			frames_bad++;
		end
		for (int i = 0; i < FRAME_BYTES; i++)
			push_result(1'b1, 4'(i), dec_b[i], sum_ok, i == FRAME_BYTES - 1);
	endtask

	task automatic send_request(logic kind, logic [31:0] t);
		in_item_t req;
		int       idle;
		req.req_type = kind;
		req.edge_time_us = t;
		idle = 0;
		while ($urandom_range(99) < send_idle_pct && idle < 40)
			idle++;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do @(posedge clk); while (in_stall);
		decode_request(req);
		items_sent++;
	endtask

	task automatic edge_after(logic [31:0] delta);
		tx_time = tx_time + delta;
		send_request(REQ_EDGE, tx_time);
	endtask

	task automatic send_clear();
		send_request(REQ_CLEAR, $urandom());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HALF_MIN: half_min_us = data[15:0];
			CFG_HALF_MAX: half_max_us = data[15:0];
			CFG_SYNC_OFF: sync_off_us = data[15:0];
			CFG_GLITCH:   glitch_us = data[15:0];
			CFG_GAP:      gap_us = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] hmin, logic [15:0] hmax, logic [15:0] soff,
			logic [15:0] glim, logic [31:0] gap);
		wait_idle();
		write_reg(CFG_HALF_MIN, {16'h0, hmin});
		write_reg(CFG_HALF_MAX, {16'h0, hmax});
		write_reg(CFG_SYNC_OFF, {16'h0, soff});
		write_reg(CFG_GLITCH, {16'h0, glim});
		write_reg(CFG_GAP, gap);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// gap, preamble, sync, then manchester data; break_bit >= 0 spoils that bit
	task automatic send_frame(bit good_sum, int break_bit);
		logic [7:0]       dec [FRAME_BYTES];
		logic [7:0]       raw_b;
		logic [NBITS-1:0] word;
		logic [3:0]       sum;
		logic             prev;
		logic             b;
		sum = CHK_SEED[3:0] ^ CHK_SEED[7:4];
		for (int i = 2; i < FRAME_BYTES; i++) begin
			dec[i] = 8'($urandom());
			sum ^= dec[i][3:0] ^ dec[i][7:4];
		end
		dec[1] = good_sum ? {CHK_HI, sum} : 8'($urandom());
		raw_b = 8'($urandom());
		word = '0;
		word[NBITS-1 -: 8] = raw_b;
		for (int i = 1; i < FRAME_BYTES; i++) begin
			raw_b = raw_b ^ dec[i];
			word[NBITS-1-8*i -: 8] = raw_b;
		end
		edge_after(gap_us + 1 + $urandom_range(0, 3000));
		repeat ($urandom_range(0, 4))
			edge_after($urandom_range(2401, 2699));
		edge_after($urandom_range(4701, 4999));
		tx_time = tx_time + sync_off_us;
		prev = 1'b1;
		for (int k = 0; k < NBITS; k++) begin
			b = word[NBITS-1-k];
			if (k == break_bit) begin
				edge_after({half_max_us, 1'b0} + $urandom_range(0, 300));
				return;
			end
			if ($urandom_range(99) < 3)
				edge_after($urandom_range(0, glitch_us));
			if (b != prev) begin
				edge_after($urandom_range(2 * half_min_us + 1, 2 * half_max_us - 1));
			end else begin
				edge_after($urandom_range(half_min_us + 1, half_max_us - 1));
				if (k != NBITS - 1)
					edge_after($urandom_range(half_min_us + 1, half_max_us - 1));
			end
			prev = b;
		end
	endtask

	task automatic send_noise(int n);
		repeat (n) begin
			case ($urandom_range(4))
				0: send_clear();
				1: edge_after($urandom_range(0, 300));
				2: edge_after($urandom_range(0, 6000));
				3: edge_after($urandom_range(0, 250000));
				default: edge_after($urandom());
			endcase
		end
	endtask

	task automatic test_basic_sequence();
		send_request(REQ_CLEAR, 32'hFFFF_FFFF);
		send_request(REQ_EDGE, 32'h0);
		tx_time = 32'd50000;
		send_request(REQ_EDGE, tx_time);
		// gap into preamble hunt just below the wrap point
		tx_time = 32'hFFFF_F000;
		send_request(REQ_EDGE, tx_time);
		edge_after(2500);
		edge_after(50);
		edge_after(2600);
		edge_after(3000);
		edge_after(1000);
		edge_after(100001);
		edge_after(4800);
		tx_time = tx_time + sync_off_us;
		edge_after(1200);
		edge_after(650);
		edge_after(650);
		edge_after(700);
		// full bit while a half is pending
		edge_after(1200);
		edge_after(3000);
		edge_after(500);
		send_clear();
		edge_after(10);
	endtask

	task automatic test_register_extremes();
		edge_after(gap_us + 1);
		set_config(16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		edge_after(32'h0000_FFFF);
		edge_after(32'h0001_0000);
		edge_after($urandom());
		send_clear();
		set_config(16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h0);
		edge_after(1);
		edge_after(0);
		edge_after(4800);
		set_config(16'h0, 16'hFFFF, 16'h0, 16'h0, 32'hFFFF_FFFE);
		// one microsecond behind the last activity is the only gap left
		edge_after(32'hFFFF_FFFF);
		edge_after(4800);
		edge_after(70000);
		edge_after(1);
		edge_after(200000);
		send_clear();
	endtask

	task automatic test_window_overlap();
		set_config(16'd500, 16'd1500, 16'd650, 16'd100, 32'd100000);
		edge_after(100001);
		edge_after(4800);
		tx_time = tx_time + sync_off_us;
		edge_after(1200);
		edge_after(700);
		edge_after(700);
		edge_after(2500);
		edge_after(1500);
	endtask

	task automatic test_traffic(int snd_pct, int rcv_pct, logic [15:0] hmin,
			logic [15:0] hmax, logic [15:0] soff, logic [15:0] glim, logic [31:0] gap,
			int n_items);
		int start;
		int pick;
		set_config(hmin, hmax, soff, glim, gap);
		send_idle_pct = snd_pct;
		stall_pct = rcv_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_frame(next_good_sum, -1);
				next_good_sum = ~next_good_sum;
			end else if (pick < 80) begin
				send_frame(1'($urandom_range(1)), $urandom_range(0, NBITS - 1));
			end else begin
				send_noise($urandom_range(3, 8));
			end
		end
	endtask

	task automatic test_backpressure();
		set_config(16'd500, 16'd800, 16'd650, 16'd100, 32'd100000);
		send_idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				hold_results <= 1'b1;
				repeat (400) @(posedge clk);
				hold_results <= 1'b0;
			end
		join_none
		send_noise(20);
	endtask

	// result check and output stall
	always @(posedge clk) begin : check_results
		out_item_t got;
		out_item_t want;
		if (out_valid && !out_stall) begin
			got = out_item;
			results_seen++;
			if (expected_results.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = expected_results.pop_front();
				if (got.rx_state !== want.rx_state)
					flag_error($sformatf("result %0d rx_state %0d, expected %0d",
						results_seen, got.rx_state, want.rx_state));
				if (got.bit_count !== want.bit_count)
					flag_error($sformatf("result %0d bit_count %0d, expected %0d",
						results_seen, got.bit_count, want.bit_count));
				if (got.byte_valid !== want.byte_valid)
					flag_error($sformatf("result %0d byte_valid %0b, expected %0b",
						results_seen, got.byte_valid, want.byte_valid));
				if (got.byte_index !== want.byte_index)
					flag_error($sformatf("result %0d byte_index %0d, expected %0d",
						results_seen, got.byte_index, want.byte_index));
				if (got.byte_value !== want.byte_value)
					flag_error($sformatf("result %0d byte_value %02h, expected %02h",
						results_seen, got.byte_value, want.byte_value));
				if (got.checksum_ok !== want.checksum_ok)
					flag_error($sformatf("result %0d checksum_ok %0b, expected %0b",
						results_seen, got.checksum_ok, want.checksum_ok));
				if (got.last !== want.last)
					flag_error($sformatf("result %0d last %0b, expected %0b",
						results_seen, got.last, want.last));
			end
		end
		out_stall <= hold_results || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_sequence();
		test_register_extremes();
		test_window_overlap();
		test_traffic(14, 78, 16'd500, 16'd800, 16'd650, 16'd100, 32'd100000, 120);
		test_traffic(78, 14, 16'd300, 16'd450, 16'd0, 16'd0, 32'd20000, 120);
		test_traffic(0, 0, 16'd40000, 16'd50000, 16'hFFFF, 16'd2000, 32'd200000, 120);
		test_backpressure();
		wait_idle();
		if (expected_results.size() != 0)
			flag_error($sformatf("%0d expected results never arrived",
				expected_results.size()));
		$display("covered %0d requests and %0d results over %0d register settings",
			items_sent, results_seen, settings_count);
		$display("frames decoded: %0d with good checksum, %0d with bad checksum",
			frames_ok, frames_bad);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/rfem_pkg.sv
rtl/rfem_ram.sv
rtl/rfem_dp.sv
rtl/rfem_ctrl.sv
rtl/rf_edge_manchester_frame_receiver_unit.sv
verif/tb_top.sv
